// ===== rtl/core/assert_macros.svh =====
// Assertion helpers for the core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_CHK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`else

`define ASSERT_CHK(label, clk, rst_n, prop, msg)

`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg)

`endif

`endif

// ===== rtl/core/spsm_pkg.sv =====
package spsm_pkg;

  localparam int MaxTerms = 32;
  localparam int AddrW    = (MaxTerms > 1) ? $clog2(MaxTerms) : 1;
  localparam int CntW     = $clog2(MaxTerms + 1);

  localparam int ModeW     = 2;
  localparam int CoefW     = 16;
  localparam int ExpW      = 16;
  localparam int ResCoefW  = CoefW + 1;
  localparam int TermW     = CoefW + ExpW;

  typedef enum logic [ModeW-1:0] {
    ModeLoadFirst  = 2'd0,
    ModeLoadSecond = 2'd1,
    ModeCompute    = 2'd2
  } mode_e;

  // decision of one merge step
  typedef struct packed {
    logic take1;
    logic take2;
    logic emit;
  } merge_step_t;

endpackage

// ===== rtl/core/spsm_if.sv =====
interface spsm_in_if;
  logic                                 valid;
  logic                                 ready;
  logic        [spsm_pkg::ModeW-1:0]    mode;
  logic signed [spsm_pkg::CoefW-1:0]    coefficient;
  logic        [spsm_pkg::ExpW-1:0]     exponent;

  modport source (output valid, mode, coefficient, exponent, input ready);
  modport sink   (input valid, mode, coefficient, exponent, output ready);
endinterface

interface spsm_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [spsm_pkg::ResCoefW-1:0] result_coefficient;
  logic        [spsm_pkg::ExpW-1:0]     result_exponent;
  logic                                 last;
  logic                                 empty_res;

  modport source (output valid, result_coefficient, result_exponent, last, empty_res,
                  input ready);
  modport sink   (input valid, result_coefficient, result_exponent, last, empty_res,
                  output ready);
endinterface

// ===== rtl/core/sparse_poly_subtract_merge.sv =====
// Sparse polynomial subtraction, first list minus second list.
// in_i carries items with mode, coefficient and exponent. Mode 0 appends a
// term to the first list, mode 1 to the second; a load gives no result. A
// zero coefficient, a full list or an exponent that is not below the
// previous one in that list drops the load. Mode 3 is ignored.
// Mode 2 starts the merge: each cycle takes one term, or a pair with equal
// exponents, from the stores unless the merge is stalled on the output, and
// ready stays low until the compute ends. The merge unit is one compare and
// one 17-bit subtractor; one term is kept pending so that the final result
// can be flagged last, so a result reaches out_o only once the next nonzero
// term is found or, for the final one, once the stores are used up and the
// output register is free.
// out_o carries result_coefficient, result_exponent, last and empty_res,
// highest exponent first. An empty difference gives one result with
// empty_res and last set and the other fields zero. Both lists are cleared
// at the end of a compute.
// Results sit in an output register; when out_o.ready is low the merge
// stalls once the pending term and the output register are both full.
// Reset (rst_ni low) empties both lists and drops any result in flight.
`include "assert_macros.svh"

module sparse_poly_subtract_merge (
  input  logic  clk_i,
  input  logic  rst_ni,
  spsm_in_if.sink    in_i,
  spsm_out_if.source out_o
);
  import spsm_pkg::*;

  localparam logic StIdle  = 1'b0;
  localparam logic StMerge = 1'b1;

  logic state_q, state_d;
  logic [CntW-1:0] cnt1_q, cnt1_d, cnt2_q, cnt2_d;
  logic [CntW-1:0] i_q, i_d, j_q, j_d;
  logic [ExpW-1:0] last1_q, last1_d, last2_q, last2_d;

  logic                       pend_valid_q, pend_valid_d;
  logic signed [ResCoefW-1:0] pend_coef_q, pend_coef_d;
  logic        [ExpW-1:0]     pend_exp_q, pend_exp_d;

  logic                       out_valid_q, out_valid_d;
  logic signed [ResCoefW-1:0] out_coef_q, out_coef_d;
  logic        [ExpW-1:0]     out_exp_q, out_exp_d;
  logic                       out_last_q, out_last_d;
  logic                       out_empty_q, out_empty_d;
  logic                       out_load;
  logic                       out_free;

  logic           in_fire;
  logic           we1, we2;
  logic           ok1, ok2;
  logic [TermW-1:0] rd1, rd2;
  logic [TermW-1:0] wdata;
  logic           have1, have2;
  merge_step_t    step;
  logic signed [ResCoefW-1:0] alu_coef;
  logic        [ExpW-1:0]     alu_exp;

  assign in_i.ready = state_q == StIdle;
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;
  assign wdata      = {in_i.coefficient, in_i.exponent};

  assign ok1 = (in_i.coefficient != '0) && (cnt1_q < CntW'(MaxTerms))
            && ((cnt1_q == '0) || (in_i.exponent < last1_q));
  assign ok2 = (in_i.coefficient != '0) && (cnt2_q < CntW'(MaxTerms))
            && ((cnt2_q == '0) || (in_i.exponent < last2_q));

  assign have1 = i_q != cnt1_q;
  assign have2 = j_q != cnt2_q;

  // read address follows the next index, so the registered read lines up
  spsm_ram #(.Width(TermW), .Depth(MaxTerms)) u_ram1 (
    .clk_i   (clk_i),
    .we_i    (we1),
    .waddr_i (cnt1_q[AddrW-1:0]),
    .wdata_i (wdata),
    .raddr_i (i_d[AddrW-1:0]),
    .rdata_o (rd1)
  );

  spsm_ram #(.Width(TermW), .Depth(MaxTerms)) u_ram2 (
    .clk_i   (clk_i),
    .we_i    (we2),
    .waddr_i (cnt2_q[AddrW-1:0]),
    .wdata_i (wdata),
    .raddr_i (j_d[AddrW-1:0]),
    .rdata_o (rd2)
  );

  spsm_alu u_alu (
    .have1_i (have1),
    .have2_i (have2),
    .coef1_i (rd1[TermW-1:ExpW]),
    .exp1_i  (rd1[ExpW-1:0]),
    .coef2_i (rd2[TermW-1:ExpW]),
    .exp2_i  (rd2[ExpW-1:0]),
    .step_o  (step),
    .coef_o  (alu_coef),
    .exp_o   (alu_exp)
  );

  always_comb begin
    state_d      = state_q;
    cnt1_d       = cnt1_q;
    cnt2_d       = cnt2_q;
    i_d          = i_q;
    j_d          = j_q;
    last1_d      = last1_q;
    last2_d      = last2_q;
    pend_valid_d = pend_valid_q;
    pend_coef_d  = pend_coef_q;
    pend_exp_d   = pend_exp_q;
    out_load     = 1'b0;
    out_coef_d   = out_coef_q;
    out_exp_d    = out_exp_q;
    out_last_d   = out_last_q;
    out_empty_d  = out_empty_q;
    we1          = 1'b0;
    we2          = 1'b0;

    unique case (state_q)
      StIdle: begin
        if (in_fire) begin
          case (in_i.mode)
            ModeLoadFirst: begin
              if (ok1) begin
                we1     = 1'b1;
                cnt1_d  = cnt1_q + CntW'(1);
                last1_d = in_i.exponent;
              end
            end
            ModeLoadSecond: begin
              if (ok2) begin
                we2     = 1'b1;
                cnt2_d  = cnt2_q + CntW'(1);
                last2_d = in_i.exponent;
              end
            end
            ModeCompute: state_d = StMerge;
            default: ;
          endcase
        end
      end
      StMerge: begin
        if (have1 || have2) begin
          // stall only when a new term would push the pending one out
          if (!(step.emit && pend_valid_q && !out_free)) begin
            i_d = i_q + CntW'(step.take1);
            j_d = j_q + CntW'(step.take2);
            if (step.emit) begin
              if (pend_valid_q) begin
                out_load    = 1'b1;
                out_coef_d  = pend_coef_q;
                out_exp_d   = pend_exp_q;
                out_last_d  = 1'b0;
                out_empty_d = 1'b0;
              end
              pend_valid_d = 1'b1;
              pend_coef_d  = alu_coef;
              pend_exp_d   = alu_exp;
            end
          end
        end else if (out_free) begin
          out_load     = 1'b1;
          out_coef_d   = pend_valid_q ? pend_coef_q : '0;
          out_exp_d    = pend_valid_q ? pend_exp_q : '0;
          out_last_d   = 1'b1;
          out_empty_d  = !pend_valid_q;
          pend_valid_d = 1'b0;
          i_d          = '0;
          j_d          = '0;
          cnt1_d       = '0;
          cnt2_d       = '0;
          state_d      = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase

    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      cnt1_q       <= '0;
      cnt2_q       <= '0;
      i_q          <= '0;
      j_q          <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      cnt1_q       <= cnt1_d;
      cnt2_q       <= cnt2_d;
      i_q          <= i_d;
      j_q          <= j_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    last1_q     <= last1_d;
    last2_q     <= last2_d;
    pend_coef_q <= pend_coef_d;
    pend_exp_q  <= pend_exp_d;
    out_coef_q  <= out_coef_d;
    out_exp_q   <= out_exp_d;
    out_last_q  <= out_last_d;
    out_empty_q <= out_empty_d;
  end

  assign out_o.valid              = out_valid_q;
  assign out_o.result_coefficient = out_coef_q;
  assign out_o.result_exponent    = out_exp_q;
  assign out_o.last               = out_last_q;
  assign out_o.empty_res          = out_empty_q;

  `ASSERT_CHK(a_idx_bound, clk_i, rst_ni,
    (i_q <= cnt1_q) && (j_q <= cnt2_q), "merge index past list end")
  `ASSERT_CHK(a_empty_form, clk_i, rst_ni,
    !(out_valid_q && out_empty_q) || (out_last_q && out_coef_q == '0 && out_exp_q == '0),
    "malformed empty result")
  `ASSERT_CHK(a_nonzero, clk_i, rst_ni,
    !(out_valid_q && !out_empty_q) || (out_coef_q != '0), "zero coefficient emitted")
  `ASSERT_NEXT(a_clear, clk_i, rst_ni, state_q == StMerge && state_d == StIdle,
    cnt1_q == '0 && cnt2_q == '0 && !pend_valid_q, "lists not cleared after compute")
  `ASSERT_NEXT(a_idle_idx, clk_i, rst_ni, state_q == StIdle,
    i_q == '0 && j_q == '0, "merge index not at zero in idle")

endmodule

// ===== rtl/core/spsm_ram.sv =====
module spsm_ram #(
  parameter int Width = 32,
  parameter int Depth = 32
) (
  input  logic                                           clk_i,
  input  logic                                           we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0]   waddr_i,
  input  logic [Width-1:0]                               wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0]   raddr_i,
  output logic [Width-1:0]                               rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/spsm_alu.sv =====
module spsm_alu (
  input  logic                                 have1_i,
  input  logic                                 have2_i,
  input  logic signed [spsm_pkg::CoefW-1:0]    coef1_i,
  input  logic        [spsm_pkg::ExpW-1:0]     exp1_i,
  input  logic signed [spsm_pkg::CoefW-1:0]    coef2_i,
  input  logic        [spsm_pkg::ExpW-1:0]     exp2_i,
  output spsm_pkg::merge_step_t                step_o,
  output logic signed [spsm_pkg::ResCoefW-1:0] coef_o,
  output logic        [spsm_pkg::ExpW-1:0]     exp_o
);
  import spsm_pkg::*;

  logic signed [ResCoefW-1:0] opa;
  logic signed [ResCoefW-1:0] opb;
  logic signed [ResCoefW-1:0] diff;
  logic                       take1;
  logic                       take2;

  always_comb begin
    if (have1_i && have2_i) begin
      take1 = exp1_i >= exp2_i;
      take2 = exp2_i >= exp1_i;
    end else begin
      take1 = have1_i;
      take2 = !have1_i;
    end
  end

  // one subtractor covers all three cases: c1, -c2 and c1 - c2
  assign opa  = take1 ? ResCoefW'(coef1_i) : '0;
  assign opb  = take2 ? ResCoefW'(coef2_i) : '0;
  assign diff = opa - opb;

  assign coef_o       = diff;
  assign exp_o        = take1 ? exp1_i : exp2_i;
  assign step_o.take1 = take1;
  assign step_o.take2 = take2;
  assign step_o.emit  = diff != '0;

endmodule

// ===== bench/sparse_poly_subtract_merge_test.sv =====
module sparse_poly_subtract_merge_test;
  timeunit 1ns;
  timeprecision 1ps;

  import spsm_pkg::*;

  localparam logic [ModeW-1:0] ModeUnused = 2'd3;
  localparam int IdleLimit = 4000;
  localparam int PhaseItems = 55;

  typedef struct packed {
    logic [ModeW-1:0]        mode;
    logic signed [CoefW-1:0] coefficient;
    logic [ExpW-1:0]         exponent;
  } term_item_t;

  typedef struct packed {
    logic signed [ResCoefW-1:0] coefficient;
    logic [ExpW-1:0]            exponent;
    logic                       last;
    logic                       is_empty;
  } diff_term_t;

  logic clk_i;
  logic rst_ni;

  spsm_in_if  in_bus ();
  spsm_out_if out_bus ();

  sparse_poly_subtract_merge u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_bus),
    .out_o (out_bus)
  );

  term_item_t pending[$];
  term_item_t cur_item;
  diff_term_t due_terms[$];

  // mirror of the two term stores; index 0 is the minuend list
  logic signed [CoefW-1:0] poly_coef [2][MaxTerms];
  logic [ExpW-1:0]         poly_exp  [2][MaxTerms];
  int                      poly_len  [2];

  int send_idle_pct = 0;
  int stall_pct = 0;
  int item_count = 0;
  int idle_cycles = 0;
  bit failed = 1'b0;

  function automatic void subtract_polys();
    int i, j;
    logic signed [ResCoefW-1:0] a, b;
    diff_term_t t;
    diff_term_t terms[$];
    i = 0;
    j = 0;
    while (i < poly_len[0] || j < poly_len[1]) begin
      t = '0;
      if (j >= poly_len[1] || (i < poly_len[0] && poly_exp[0][i] > poly_exp[1][j])) begin
        a = poly_coef[0][i];
        t.coefficient = a;
        t.exponent = poly_exp[0][i];
        terms.push_back(t);
        i++;
      end else if (i >= poly_len[0] || poly_exp[1][j] > poly_exp[0][i]) begin
        b = poly_coef[1][j];
        t.coefficient = -b;
        t.exponent = poly_exp[1][j];
        terms.push_back(t);
        j++;
      end else begin
        a = poly_coef[0][i];
        b = poly_coef[1][j];
        t.coefficient = a - b;
        t.exponent = poly_exp[0][i];
        if (t.coefficient != 0) terms.push_back(t);
        i++;
        j++;
      end
    end
    if (terms.size() == 0) begin
      t = '0;
      t.is_empty = 1'b1;
      terms.push_back(t);
    end
    t = terms.pop_back();
    t.last = 1'b1;
    terms.push_back(t);
    foreach (terms[k]) due_terms.push_back(terms[k]);
    poly_len[0] = 0;
    poly_len[1] = 0;
  endfunction

  function automatic void update_polys(term_item_t it);
    int s;
    int n;
    s = (it.mode == ModeLoadSecond) ? 1 : 0;
    n = poly_len[s];
    if (it.mode == ModeLoadFirst || it.mode == ModeLoadSecond) begin
      if (it.coefficient != 0 && n < MaxTerms && (n == 0 || it.exponent < poly_exp[s][n-1])) begin
        poly_coef[s][n] = it.coefficient;
        poly_exp[s][n] = it.exponent;
        poly_len[s] = n + 1;
      end
    end else if (it.mode == ModeCompute) begin
      subtract_polys();
    end
  endfunction

  function automatic void push_item(logic [ModeW-1:0] m, logic signed [CoefW-1:0] c,
                                    logic [ExpW-1:0] e);
    term_item_t it;
    it.mode = m;
    it.coefficient = c;
    it.exponent = e;
    pending.push_back(it);
  endfunction

  // counted toward the phase size; ignored noise goes through push_item only
  function automatic void push_term(logic [ModeW-1:0] m, logic signed [CoefW-1:0] c,
                                    logic [ExpW-1:0] e);
    push_item(m, c, e);
    item_count++;
  endfunction

  function automatic logic signed [CoefW-1:0] rand_coef();
    logic signed [CoefW-1:0] c;
    case ($urandom_range(7))
      0: c = 16'sh7fff;
      1: c = 16'sh8000;
      default: c = CoefW'($urandom);
    endcase
    if (c == 0) c = 16'sh0001;
    return c;
  endfunction

  // m distinct exponents in falling order, each given to one list or both
  task automatic queue_poly_pair(input int m, input bit alternate);
    int e, lo, owner, step;
    logic signed [CoefW-1:0] ca, cb;
    e = 0;
    if (m > 0) e = ($urandom_range(3) == 0) ? 65535 : $urandom_range(65535, m - 1);
    for (int k = 0; k < m; k++) begin
      owner = alternate ? k % 2 : $urandom_range(2);
      ca = rand_coef();
      cb = ($urandom_range(3) == 0) ? ca : rand_coef();
      if (owner != 1) push_term(ModeLoadFirst, ca, ExpW'(e));
      if (owner != 0) push_term(ModeLoadSecond, cb, ExpW'(e));
      if ($urandom_range(11) == 0)  // exponent not below the last one: dropped
        push_item((owner == 1) ? ModeLoadSecond : ModeLoadFirst, rand_coef(),
                  ExpW'(e + $urandom_range(65535 - e, 0)));
      if ($urandom_range(19) == 0)
        push_item($urandom_range(1) ? ModeLoadSecond : ModeLoadFirst, '0, ExpW'($urandom));
      if ($urandom_range(24) == 0)
        push_item(ModeUnused, CoefW'($urandom), ExpW'($urandom));
      if (k < m - 1) begin
        lo = m - 2 - k;
        step = $urandom_range(3, 0);
        if (k == m - 2 && $urandom_range(3) == 0) e = 0;
        else if ($urandom_range(1)) e = $urandom_range(e - 1, lo);
        else e = (e - 1 - step < lo) ? lo : e - 1 - step;
      end
    end
    push_term(ModeCompute, CoefW'($urandom), ExpW'($urandom));
  endtask

  task automatic wait_drained();
    while (pending.size() != 0 || in_bus.valid || due_terms.size() != 0)
      @(negedge clk_i);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_bus.valid <= 1'b0;
    end else begin
      if (in_bus.valid && in_bus.ready) update_polys(cur_item);
      if (!in_bus.valid || in_bus.ready) begin
        if (pending.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_item = pending.pop_front();
          in_bus.valid <= 1'b1;
          in_bus.mode <= cur_item.mode;
          in_bus.coefficient <= cur_item.coefficient;
          in_bus.exponent <= cur_item.exponent;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    diff_term_t want;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      if (due_terms.size() == 0) begin
        $error("result with nothing expected: coefficient %0d exponent %0d",
               out_bus.result_coefficient, out_bus.result_exponent);
        failed = 1'b1;
      end else begin
        want = due_terms.pop_front();
        if (out_bus.result_coefficient !== want.coefficient) begin
          $error("result_coefficient: expected %0d, got %0d",
                 want.coefficient, out_bus.result_coefficient);
          failed = 1'b1;
        end
        if (out_bus.result_exponent !== want.exponent) begin
          $error("result_exponent: expected %0d, got %0d",
                 want.exponent, out_bus.result_exponent);
          failed = 1'b1;
        end
        if (out_bus.last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, out_bus.last);
          failed = 1'b1;
        end
        if (out_bus.empty_res !== want.is_empty) begin
          $error("empty_res: expected %0b, got %0b", want.is_empty, out_bus.empty_res);
          failed = 1'b1;
        end
      end
    end
    out_bus.ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      idle_cycles = 0;
    end else if (rst_ni) begin
      idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("** sparse_poly_subtract_merge: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    in_bus.valid = 1'b0;
    in_bus.mode = ModeLoadFirst;
    in_bus.coefficient = '0;
    in_bus.exponent = '0;
    out_bus.ready = 1'b0;
    poly_len[0] = 0;
    poly_len[1] = 0;
    rst_ni = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    // compute on empty stores
    push_item(ModeCompute, '0, '0);
    // extremes, zero coefficient, repeated exponent, unused mode
    push_item(ModeLoadFirst, 16'sh7fff, 16'hffff);
    push_item(ModeLoadFirst, '0, 16'd100);
    push_item(ModeLoadFirst, 16'sh0001, 16'hffff);
    push_item(ModeLoadFirst, 16'sh8000, 16'h0000);
    push_item(ModeLoadSecond, 16'sh8000, 16'hffff);
    push_item(ModeLoadSecond, 16'sh7fff, 16'h0001);
    push_item(ModeUnused, -16'sd1, 16'hffff);
    push_item(ModeCompute, -16'sd1, 16'hffff);
    // full cancellation
    push_item(ModeLoadFirst, 16'sd5, 16'd10);
    push_item(ModeLoadSecond, 16'sd5, 16'd10);
    push_item(ModeCompute, 16'sh5555, 16'haaaa);
    // negation of the most negative coefficient
    push_item(ModeLoadSecond, 16'sh8000, 16'd7);
    push_item(ModeCompute, '0, '0);
    // most negative difference
    push_item(ModeLoadFirst, 16'sh8000, 16'd3);
    push_item(ModeLoadSecond, 16'sh7fff, 16'd3);
    push_item(ModeLoadFirst, 16'sd1, 16'd2);
    push_item(ModeCompute, '0, '0);
    // rising exponent in the second list is dropped
    push_item(ModeLoadSecond, 16'sd2, 16'd5);
    push_item(ModeLoadSecond, 16'sd3, 16'd9);
    push_item(ModeCompute, '0, '0);
    wait_drained();

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 73; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 73; end
        default: begin send_idle_pct = 29; stall_pct = 29; end
      endcase
      item_count = 0;
      // both lists overfilled with disjoint exponents: full-list drops, longest run
      if (p == 0 || p == 2) queue_poly_pair(70, 1'b1);
      while (item_count < PhaseItems)
        queue_poly_pair(($urandom_range(9) == 0) ? $urandom_range(16, 7) : $urandom_range(6, 0),
                        1'b0);
      wait_drained();
    end

    repeat (80) @(negedge clk_i);
    if (!failed && due_terms.size() == 0) begin
      $display("** sparse_poly_subtract_merge: PASSED **");
    end else begin
      $display("** sparse_poly_subtract_merge: FAILED **");
    end
    $finish;
  end

endmodule
